FILE: rtl/fircirc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fircirc_pkg
// shared types and fixed widths for the circular history fir core
// ----------------------------------------------------------------------------
package fircirc_pkg;

	// accumulator and result width
	localparam int ACC_BITS = 40;
	// coefficient index field width
	localparam int IDX_BITS = 7;
	// tap count register width
	localparam int TAP_CNT_BITS = 8;

	// request kinds carried in tuser
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_MAC   = 4'b0100,
		ST_DRAIN = 4'b1000
	} seq_state_t;

endpackage

FILE: rtl/fir_filter_circular_history_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_circular_history_core
// direct-form fir filter with a circular sample history and one shared mac
// ----------------------------------------------------------------------------
//
// channel   dir   handshake                 payload
// s_*       in    s_tvalid / s_tready       tdata: sample, coeff_index, coeff_value
//                                           tuser: op, tlast: end_of_block
// m_*       out   m_tvalid / m_tready       tdata: filtered_value, tlast: end_of_block_out
// cfg_*     in    cfg_valid / cfg_ready     cfg_data: tap_count
//
// a filter request is accepted in idle, then walks the clamped tap count at
// one tap per cycle through the shared multiply-accumulate, then drains
// a coefficient load is taken in idle and gives no result
// after reset a clearing pass zeroes both memories, s_tready low
// the result sits in an output register, so the next request is taken while
// it waits; a filter request holds in drain until that register is free
//
module fir_filter_circular_history_core
	import fircirc_pkg::*;
#(
	parameter int MAX_TAPS    = 128,
	parameter int SAMPLE_BITS = 16,
	parameter int COEFF_BITS  = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// sample, coeff_index, coeff_value from bit 0 up, zero filled to bytes
	input  logic [((SAMPLE_BITS+IDX_BITS+COEFF_BITS+7)/8)*8-1:0] s_tdata,
	// op
	input  logic                      s_tuser,
	input  logic                      s_tlast,
	// result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// filtered_value
	output logic [ACC_BITS-1:0]       m_tdata,
	output logic                      m_tlast,
	// configuration write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [TAP_CNT_BITS-1:0]   cfg_data
);

	localparam int PW     = $clog2(MAX_TAPS);
	localparam int TW     = $clog2(MAX_TAPS + 1);
	localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
	localparam int SUM_W  = ((PROD_W > ACC_BITS) ? PROD_W : ACC_BITS) + 1;
	localparam int IDX_LO = SAMPLE_BITS;
	localparam int CV_LO  = SAMPLE_BITS + IDX_BITS;

	localparam logic [PW-1:0] LAST_POS = PW'(MAX_TAPS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'({1'b0, {(ACC_BITS-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// request fields
	logic signed [SAMPLE_BITS-1:0] in_sample;
	logic [IDX_BITS-1:0]           in_idx;
	logic signed [COEFF_BITS-1:0]  in_coeff;
	logic                          accept;
	logic                          idx_ok;

	assign in_sample = s_tdata[SAMPLE_BITS-1:0];
	assign in_idx    = s_tdata[CV_LO-1:IDX_LO];
	assign in_coeff  = s_tdata[CV_LO+COEFF_BITS-1:CV_LO];
	assign accept    = s_tvalid && s_tready;
	assign idx_ok    = 32'(in_idx) < 32'(MAX_TAPS);

	// sequencer and control registers
	seq_state_t        state_q;
	logic [PW-1:0]     clr_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     j_q;
	logic [PW-1:0]     k_q;
	logic [TW-1:0]     remain_q;
	logic [TAP_CNT_BITS-1:0] tap_count_q;
	logic              eob_q;
	logic [TW-1:0]     taps_eff;

	// mac pipeline
	logic                          vld_s1;
	logic                          vld_s2;
	logic signed [COEFF_BITS-1:0]  coeff_rd_s1;
	logic signed [SAMPLE_BITS-1:0] hist_rd_s1;
	logic signed [PROD_W-1:0]      prod_s2;
	logic signed [ACC_BITS-1:0]    acc_q;
	logic signed [SUM_W-1:0]       sum;
	logic signed [ACC_BITS-1:0]    sum_sat;

	// output register
	logic                  m_tvalid_q;
	logic [ACC_BITS-1:0]   m_tdata_q;
	logic                  m_tlast_q;
	logic                  out_free;
	logic                  drain_done;

	// memories
	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
	logic signed [COEFF_BITS-1:0]  coeff_mem [MAX_TAPS];
	logic                          hist_we;
	logic [PW-1:0]                 hist_waddr;
	logic signed [SAMPLE_BITS-1:0] hist_wdata;
	logic                          coeff_we;
	logic [PW-1:0]                 coeff_waddr;
	logic signed [COEFF_BITS-1:0]  coeff_wdata;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;

	assign out_free   = !m_tvalid_q || m_tready;
	assign drain_done = (state_q == ST_DRAIN) && !vld_s1 && !vld_s2 && out_free;

	// tap count clamp: zero acts as one, above the depth acts as the depth
	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TW'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = TW'(MAX_TAPS);
		end else begin
			taps_eff = TW'(tap_count_q);
		end
	end

	// memory write port selection, clearing pass owns both ports
	always_comb begin
		hist_we     = 1'b0;
		hist_waddr  = pos_q;
		hist_wdata  = in_sample;
		coeff_we    = 1'b0;
		coeff_waddr = PW'(in_idx);
		coeff_wdata = in_coeff;
		if (state_q == ST_CLEAR) begin
			hist_we     = 1'b1;
			hist_waddr  = clr_q;
			hist_wdata  = '0;
			coeff_we    = 1'b1;
			coeff_waddr = clr_q;
			coeff_wdata = '0;
		end else if (accept) begin
			hist_we  = (s_tuser == OP_FILTER);
			coeff_we = (s_tuser == OP_LOAD) && idx_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (coeff_we) begin
			coeff_mem[coeff_waddr] <= coeff_wdata;
		end
		// registered reads for the mac walk
		coeff_rd_s1 <= coeff_mem[j_q];
		hist_rd_s1  <= hist_mem[k_q];
	end

	// shared multiplier and saturating accumulate
	assign sum = SUM_W'(acc_q) + SUM_W'(prod_s2);

	always_comb begin
		if (sum > SAT_HI) begin
			sum_sat = ACC_BITS'(SAT_HI);
		end else if (sum < SAT_LO) begin
			sum_sat = ACC_BITS'(SAT_LO);
		end else begin
			sum_sat = ACC_BITS'(sum);
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(coeff_rd_s1) * PROD_W'(hist_rd_s1);
		if (accept) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= sum_sat;
		end
	end

	// tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_CNT_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			pos_q    <= '0;
			j_q      <= '0;
			k_q      <= '0;
			remain_q <= '0;
			eob_q    <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_MAC);
			vld_s2 <= vld_s1;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == LAST_POS) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (s_tuser == OP_FILTER)) begin
						j_q      <= '0;
						k_q      <= pos_q;
						remain_q <= taps_eff;
						eob_q    <= s_tlast;
						pos_q    <= (pos_q == LAST_POS) ? '0 : pos_q + PW'(1);
						state_q  <= ST_MAC;
					end
				end
				ST_MAC: begin
					// one tap issued per cycle, newest sample first
					j_q      <= j_q + PW'(1);
					k_q      <= (k_q == '0) ? LAST_POS : k_q - PW'(1);
					remain_q <= remain_q - TW'(1);
					if (remain_q == TW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (drain_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_done) begin
			m_tdata_q <= acc_q;
			m_tlast_q <= eob_q;
		end
	end

	// the mac pipeline is empty whenever a request can be taken
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("mac pipeline busy while idle");

	// a tap is still owed whenever the walk runs
	a_mac_remain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (remain_q != '0))
		else $error("mac walk with no tap left");

	// a result only appears at the end of a drain
	a_out_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DRAIN))
		else $error("result raised outside drain");

	// the walk never runs beyond the memory depth
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MAC) && (remain_q == TW'(1))) |-> (32'(j_q) + 1 <= 32'(MAX_TAPS)))
		else $error("tap walk beyond depth");

endmodule
